[sv/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// Shared widths and defaults for the random permutation shuffler.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam int MAX_N_DEF     = 1024;
  localparam int FRAC_BITS_DEF = 32;

  // fixed field widths
  localparam int UF_W  = 32;
  localparam int VAL_W = 10;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] PERM_SIZE_RST = 11'd1024;

  // generation tag kept with each slot, tag zero means never written
  localparam int                 EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam int ENTRY_W = EPOCH_W + VAL_W;

endpackage

`default_nettype wire

[sv/rps_slot_mem.sv]
// ----------------------------------------------------------------------------
// rps_slot_mem
// Slot store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_slot_mem
  import rps_pkg::*;
#(
  parameter int MAX_N = MAX_N_DEF,
  localparam int IDX_W = $clog2(MAX_N)
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_addr_a,
  input  wire logic [IDX_W-1:0]   rd_addr_b,
  output logic      [ENTRY_W-1:0] rd_data_a,
  output logic      [ENTRY_W-1:0] rd_data_b,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [MAX_N];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

[sv/rps_pick.sv]
// ----------------------------------------------------------------------------
// rps_pick
// Scales the random fraction by the live slot count and clamps the slot index.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_pick
  import rps_pkg::*;
#(
  parameter int MAX_N     = MAX_N_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_N),
  localparam int N_W   = $clog2(MAX_N + 1)
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [N_W-1:0]   remaining,
  input  wire logic [UF_W-1:0]  frac,
  output logic      [IDX_W-1:0] pick,
  output logic      [IDX_W-1:0] tail
);

  localparam int PROD_W = N_W + UF_W;

  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    rem_r;
  logic [PROD_W-1:0] scaled;
  logic [N_W-1:0]    rem_m1;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(remaining) * PROD_W'(frac);
      rem_r  <= remaining;
    end
  end

  always_comb begin
    scaled = prod_r >> FRAC_BITS;
    rem_m1 = rem_r - N_W'(1);
    tail   = rem_m1[IDX_W-1:0];
    // fractions of one or more can only land past the last live slot
    if (scaled >= PROD_W'(rem_r)) begin
      pick = rem_m1[IDX_W-1:0];
    end else begin
      pick = scaled[IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/random_permutation_shuffler_unit.sv]
// ----------------------------------------------------------------------------
// random_permutation_shuffler_unit
// Draws random permutations of 0..N-1 in swap-with-last Fisher-Yates order.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_* carries one 32-bit uniform fraction and
//   yields exactly one output transaction on out_*: the next permutation
//   element, with out_last set on the final element of a permutation.
//   cfg_wr_en writes the permutation size (0 acts as 1, values above MAX_N
//   saturate) and restarts the permutation; write it only while idle.
//   Each input is multiplied into a register, both slots are read through
//   the registered read ports, then the result is registered at write-back
//   to the single-write-port slot memory; the next input waits for write-back.
//   Slots carry an 8-bit generation tag instead of written marks. After
//   reset, and once every 255 permutations, a clearing pass over all MAX_N
//   slots rewrites every tag to zero; in_stall stays high meanwhile.
//   A stalled result sits in the output register; one more input is taken
//   and held at write-back until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module random_permutation_shuffler_unit
  import rps_pkg::*;
#(
  parameter int MAX_N     = MAX_N_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_perm_size,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [UF_W-1:0]  in_uniform_fraction,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VAL_W-1:0] out_perm_value,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(MAX_N);
  localparam int N_W   = $clog2(MAX_N + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WB    = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   size_r, size_nxt;
  logic [IDX_W-1:0]   position_r, position_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_last_r;

  logic [31:0]        size_sat;
  logic [N_W-1:0]     n_eff;
  logic [N_W-1:0]     p_eff;
  logic [N_W-1:0]     p_inc;
  logic [N_W-1:0]     remaining;
  logic               perm_start;
  logic               need_clear;
  logic               accept;
  logic               wb_fire;

  logic [IDX_W-1:0]   pick;
  logic [IDX_W-1:0]   tail;
  logic [31:0]        pick_ext;
  logic [31:0]        tail_ext;
  logic [ENTRY_W-1:0] rd_pick;
  logic [ENTRY_W-1:0] rd_tail;
  logic [VAL_W-1:0]   pick_val;
  logic [VAL_W-1:0]   tail_val;

  logic               mem_rd_en;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;

  // effective size and position
  always_comb begin
    size_sat = 32'(size_r);
    if (size_r == '0) begin
      size_sat = 32'd1;
    end else if (32'(size_r) > 32'(MAX_N)) begin
      size_sat = 32'(MAX_N);
    end
    n_eff = size_sat[N_W-1:0];
    p_eff = N_W'(position_r);
    if (p_eff >= n_eff) begin
      p_eff = '0;
    end
    p_inc      = p_eff + N_W'(1);
    remaining  = n_eff - p_eff;
    perm_start = (p_eff == '0);
    need_clear = perm_start && (epoch_r == EPOCH_MAX);
  end

  assign in_stall = (state_r != ST_IDLE) || need_clear;
  assign accept   = in_valid && !in_stall;
  assign wb_fire  = (state_r == ST_WB) && (!out_valid_r || !out_stall);

  rps_pick #(
    .MAX_N     (MAX_N),
    .FRAC_BITS (FRAC_BITS)
  ) u_pick (
    .clk       (clk),
    .load      (accept),
    .remaining (remaining),
    .frac      (in_uniform_fraction),
    .pick      (pick),
    .tail      (tail)
  );

  // a slot whose tag is not the current generation still holds its own index
  always_comb begin
    pick_ext = 32'(pick);
    tail_ext = 32'(tail);
    if (rd_pick[ENTRY_W-1:VAL_W] == epoch_r) begin
      pick_val = rd_pick[VAL_W-1:0];
    end else begin
      pick_val = pick_ext[VAL_W-1:0];
    end
    if (rd_tail[ENTRY_W-1:VAL_W] == epoch_r) begin
      tail_val = rd_tail[VAL_W-1:0];
    end else begin
      tail_val = tail_ext[VAL_W-1:0];
    end
  end

  always_comb begin
    mem_rd_en   = (state_r == ST_READ);
    mem_wr_en   = 1'b0;
    mem_wr_addr = pick;
    mem_wr_data = {epoch_r, tail_val};
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_data = '0;
    end else if (wb_fire) begin
      mem_wr_en = 1'b1;
    end
  end

  rps_slot_mem #(
    .MAX_N     (MAX_N)
  ) u_mem (
    .clk       (clk),
    .rd_en     (mem_rd_en),
    .rd_addr_a (pick),
    .rd_addr_b (tail),
    .rd_data_a (rd_pick),
    .rd_data_b (rd_tail),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data)
  );

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    position_nxt  = position_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (need_clear) begin
          state_nxt    = ST_CLEAR;
          clr_addr_nxt = '0;
        end else if (accept) begin
          state_nxt = ST_READ;
          last_nxt  = (p_inc >= n_eff);
          if (p_inc >= n_eff) begin
            position_nxt = '0;
          end else begin
            position_nxt = p_inc[IDX_W-1:0];
          end
          if (perm_start) begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (wb_fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      ST_CLEAR: begin
        if (clr_addr_r == IDX_W'(MAX_N - 1)) begin
          state_nxt = ST_IDLE;
          epoch_nxt = '0;
        end else begin
          clr_addr_nxt = clr_addr_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // size write restarts the permutation
    if (cfg_wr_en) begin
      size_nxt     = cfg_perm_size;
      position_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      size_r      <= PERM_SIZE_RST;
      position_r  <= '0;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      position_r  <= position_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_value_r <= pick_val;
      out_last_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_perm_value = out_value_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire
